[rtl/core/rbsp_pkg.sv]
// Shared types and constants for the receive buffer sizing policy.
// Used by rbsp_apb_regs, rbsp_step and receive_buffer_sizing_policy.
package rbsp_pkg;

    localparam int unsigned FIELD_W           = 24;
    localparam int unsigned SIZE_BITS_DEFAULT = 24;
    localparam int unsigned GRAIN             = 256;
    localparam int unsigned AVG_SHIFT         = 4;
    localparam int unsigned APB_ADDR_W        = 2;
    localparam int unsigned APB_DATA_W        = 32;
    localparam int unsigned OUT_DATA_W        = 152;

    localparam logic [FIELD_W-1:0]    MIN_CAP_RESET = 24'd4096;
    localparam logic [APB_ADDR_W-1:0] ADDR_MIN_CAP  = 2'd0;

    typedef enum logic [2:0] {
        OP_INIT    = 3'd0,
        OP_PREPARE = 3'd1,
        OP_COMMIT  = 3'd2,
        OP_CONSUME = 3'd3,
        OP_DECAY   = 3'd4,
        OP_CLEAR   = 3'd5,
        OP_RELEASE = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        RELOC_NONE    = 2'd0,
        RELOC_COMPACT = 2'd1,
        RELOC_GROW    = 2'd2,
        RELOC_SHRINK  = 2'd3
    } reloc_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_COMMIT_SPAN  = 2'd1,
        ST_CONSUME_LIVE = 2'd2,
        ST_OVERFLOW     = 2'd3
    } status_t;

    typedef struct packed {
        logic [FIELD_W-1:0] capacity;
        logic [FIELD_W-1:0] read_offset;
        logic [FIELD_W-1:0] write_offset;
        logic [FIELD_W-1:0] free_bytes;
        reloc_t             relocation;
        logic [FIELD_W-1:0] move_from;
        logic [FIELD_W-1:0] move_bytes;
        status_t            status;
    } result_t;

endpackage

[rtl/core/rbsp_apb_regs.sv]
// APB register file holding the min_capacity floor.
// Depends on rbsp_pkg for address map and reset value.
module rbsp_apb_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rbsp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rbsp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rbsp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [rbsp_pkg::FIELD_W-1:0]        min_capacity
);

    logic [rbsp_pkg::FIELD_W-1:0] min_cap_reg;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr == rbsp_pkg::ADDR_MIN_CAP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_cap_reg <= rbsp_pkg::MIN_CAP_RESET;
        end else if (wr_en) begin
            min_cap_reg <= pwdata[rbsp_pkg::FIELD_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == rbsp_pkg::ADDR_MIN_CAP) begin
            prdata = rbsp_pkg::APB_DATA_W'(min_cap_reg);
        end
    end

    assign min_capacity = min_cap_reg;

endmodule

[rtl/core/rbsp_step.sv]
// Next-state and result logic for one buffer op.
// Depends on rbsp_pkg for op, relocation and status codes and the result type.
module rbsp_step #(
    parameter int unsigned SIZE_BITS = rbsp_pkg::SIZE_BITS_DEFAULT
) (
    input  logic [2:0]                   op,
    input  logic [rbsp_pkg::FIELD_W-1:0] amount,
    input  logic [rbsp_pkg::FIELD_W-1:0] min_capacity,
    input  logic [SIZE_BITS-1:0]         cap_cur,
    input  logic [SIZE_BITS-1:0]         start_cur,
    input  logic [SIZE_BITS-1:0]         end_cur,
    input  logic [SIZE_BITS-1:0]         peak_cur,
    input  logic [SIZE_BITS-1:0]         wm_cur,
    input  logic                         traffic_cur,
    output logic [SIZE_BITS-1:0]         cap_next,
    output logic [SIZE_BITS-1:0]         start_next,
    output logic [SIZE_BITS-1:0]         end_next,
    output logic [SIZE_BITS-1:0]         peak_next,
    output logic [SIZE_BITS-1:0]         wm_next,
    output logic                         traffic_next,
    output rbsp_pkg::result_t            result
);

    localparam int unsigned CW = ((SIZE_BITS > rbsp_pkg::FIELD_W) ?
                                  SIZE_BITS : rbsp_pkg::FIELD_W) + 2;
    localparam int unsigned SW = SIZE_BITS + rbsp_pkg::AVG_SHIFT + 2;
    localparam int unsigned AVG_N = 1 << rbsp_pkg::AVG_SHIFT;
    localparam logic [CW-1:0] SMASK = CW'((64'd1 << SIZE_BITS) - 64'd1);
    localparam logic [CW-1:0] GRAIN_LOW = CW'(rbsp_pkg::GRAIN - 1);

    function automatic logic [CW-1:0] round_grain(input logic [CW-1:0] n);
        round_grain = (n + GRAIN_LOW) & ~GRAIN_LOW;
    endfunction

    function automatic logic [CW-1:0] max_cw(input logic [CW-1:0] a, input logic [CW-1:0] b);
        max_cw = (a > b) ? a : b;
    endfunction

    logic [CW-1:0] cap_x, start_x, end_x, peak_x, wm_x, min_x, amt_x;
    logic [CW-1:0] live_x, free_x, need_x, init_cap, grow_cap;
    logic [SW-1:0] wm_w, avg_w;
    logic [CW-1:0] sampled_x, wm_probe, shrink_target;
    logic          shrink_ok;
    logic [CW-1:0] cap_n, start_n, end_n, peak_n, wm_n, from_n, nbytes_n, free_n;
    logic          traffic_n;
    rbsp_pkg::reloc_t  reloc_n;
    rbsp_pkg::status_t status_n;

    assign cap_x   = CW'(cap_cur);
    assign start_x = CW'(start_cur);
    assign end_x   = CW'(end_cur);
    assign peak_x  = CW'(peak_cur);
    assign wm_x    = CW'(wm_cur);
    assign min_x   = CW'(min_capacity);
    assign amt_x   = CW'(amount);

    assign live_x   = end_x - start_x;
    assign free_x   = cap_x - end_x;
    assign need_x   = live_x + amt_x;
    assign init_cap = round_grain(amt_x);
    assign grow_cap = round_grain(max_cw(max_cw(cap_x + (cap_x >> 1), min_x), need_x));

    // 1/16 watermark update with round-up
    assign wm_w      = SW'(wm_cur);
    assign avg_w     = (wm_w * SW'(AVG_N - 1) + SW'(peak_cur) + SW'(AVG_N - 1))
                       >> rbsp_pkg::AVG_SHIFT;
    assign sampled_x = CW'(avg_w[SIZE_BITS-1:0]);

    assign wm_probe      = (op == rbsp_pkg::OP_CONSUME) ? sampled_x : (wm_x >> 1);
    assign shrink_target = round_grain(max_cw(min_x, wm_probe));
    assign shrink_ok     = (cap_x > min_x) && ((cap_x >> 1) > wm_probe) &&
                           (shrink_target < cap_x);

    always_comb begin
        cap_n     = cap_x;
        start_n   = start_x;
        end_n     = end_x;
        peak_n    = peak_x;
        wm_n      = wm_x;
        traffic_n = traffic_cur;
        reloc_n   = rbsp_pkg::RELOC_NONE;
        status_n  = rbsp_pkg::ST_OK;
        from_n    = '0;
        nbytes_n  = '0;
        case (op)
            rbsp_pkg::OP_INIT: begin
                if ((amt_x != '0) && (init_cap > SMASK)) begin
                    status_n = rbsp_pkg::ST_OVERFLOW;
                end else begin
                    cap_n     = '0;
                    start_n   = '0;
                    end_n     = '0;
                    peak_n    = '0;
                    wm_n      = '0;
                    traffic_n = 1'b0;
                    if (amt_x != '0) begin
                        cap_n   = init_cap;
                        wm_n    = init_cap;
                        reloc_n = rbsp_pkg::RELOC_GROW;
                    end
                end
            end
            rbsp_pkg::OP_PREPARE: begin
                if (amt_x > free_x) begin
                    if ((cap_x - live_x) >= amt_x) begin
                        reloc_n  = rbsp_pkg::RELOC_COMPACT;
                        from_n   = start_x;
                        nbytes_n = live_x;
                        start_n  = '0;
                        end_n    = live_x;
                        wm_n     = sampled_x;
                        peak_n   = need_x;
                    end else if (grow_cap > SMASK) begin
                        status_n = rbsp_pkg::ST_OVERFLOW;
                    end else begin
                        reloc_n  = rbsp_pkg::RELOC_GROW;
                        from_n   = start_x;
                        nbytes_n = live_x;
                        cap_n    = grow_cap;
                        start_n  = '0;
                        end_n    = live_x;
                        wm_n     = grow_cap;
                        peak_n   = need_x;
                    end
                end else begin
                    peak_n = max_cw(peak_x, need_x);
                end
            end
            rbsp_pkg::OP_COMMIT: begin
                if (amt_x > free_x) begin
                    status_n = rbsp_pkg::ST_COMMIT_SPAN;
                end else begin
                    end_n     = end_x + amt_x;
                    peak_n    = max_cw(peak_x, need_x);
                    traffic_n = 1'b1;
                end
            end
            rbsp_pkg::OP_CONSUME: begin
                if (amt_x > live_x) begin
                    status_n = rbsp_pkg::ST_CONSUME_LIVE;
                end else if (amt_x == live_x) begin
                    start_n = '0;
                    end_n   = '0;
                    wm_n    = sampled_x;
                    peak_n  = '0;
                    if (shrink_ok) begin
                        cap_n   = shrink_target;
                        reloc_n = rbsp_pkg::RELOC_SHRINK;
                    end
                end else begin
                    start_n = start_x + amt_x;
                end
            end
            rbsp_pkg::OP_DECAY: begin
                if ((cap_x <= min_x) || (live_x != '0)) begin
                    cap_n = cap_x;
                end else if (traffic_cur) begin
                    traffic_n = 1'b0;
                end else begin
                    wm_n = wm_x >> 1;
                    if (shrink_ok) begin
                        cap_n   = shrink_target;
                        start_n = '0;
                        end_n   = '0;
                        reloc_n = rbsp_pkg::RELOC_SHRINK;
                    end
                end
            end
            rbsp_pkg::OP_CLEAR: begin
                start_n = '0;
                end_n   = '0;
                peak_n  = '0;
            end
            rbsp_pkg::OP_RELEASE: begin
                cap_n   = '0;
                start_n = '0;
                end_n   = '0;
                peak_n  = '0;
                wm_n    = '0;
            end
            default: begin
                cap_n = cap_x;
            end
        endcase
    end

    assign free_n = cap_n - end_n;

    assign cap_next     = cap_n[SIZE_BITS-1:0];
    assign start_next   = start_n[SIZE_BITS-1:0];
    assign end_next     = end_n[SIZE_BITS-1:0];
    assign peak_next    = peak_n[SIZE_BITS-1:0];
    assign wm_next      = wm_n[SIZE_BITS-1:0];
    assign traffic_next = traffic_n;

    always_comb begin
        result.capacity     = cap_n[rbsp_pkg::FIELD_W-1:0];
        result.read_offset  = start_n[rbsp_pkg::FIELD_W-1:0];
        result.write_offset = end_n[rbsp_pkg::FIELD_W-1:0];
        result.free_bytes   = free_n[rbsp_pkg::FIELD_W-1:0];
        result.relocation   = reloc_n;
        result.move_from    = from_n[rbsp_pkg::FIELD_W-1:0];
        result.move_bytes   = nbytes_n[rbsp_pkg::FIELD_W-1:0];
        result.status       = status_n;
    end

endmodule

[rtl/core/receive_buffer_sizing_policy.sv]
// Top level of the receive buffer sizing policy: input register, op logic, result register.
// Depends on rbsp_pkg, rbsp_apb_regs and rbsp_step.
//
//   channel   direction   ports                               payload
//   s_        in          s_tvalid s_tready s_tdata s_tuser   amount / op
//   m_        out         m_tvalid m_tready m_tdata           buffer state and move report
//   apb       in/out      psel penable pwrite paddr pwdata    min_capacity at address 0
//
// A transfer in is registered in the op register and reported from the result register.
// One op per cycle is sustained while results are taken; the buffer state updates in the same cycle as the result.
// A stalled result holds the op register, which then holds s_tready low.
// aresetn is synchronous: empty buffer, min_capacity 4096, both stages empty.
module receive_buffer_sizing_policy #(
    parameter int unsigned SIZE_BITS = rbsp_pkg::SIZE_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rbsp_pkg::FIELD_W-1:0]        s_tdata,   // [23:0] amount
    input  logic [2:0]                          s_tuser,   // [2:0] op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [23:0] capacity, [47:24] read_offset, [71:48] write_offset, [95:72] free_bytes,
    // [97:96] relocation, [121:98] move_from, [145:122] move_bytes, [147:146] status
    output logic [rbsp_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rbsp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rbsp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rbsp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic [rbsp_pkg::FIELD_W-1:0] min_capacity;

    logic                         in_valid_reg;
    logic [2:0]                   op_reg;
    logic [rbsp_pkg::FIELD_W-1:0] amount_reg;
    logic                         out_valid_reg;
    rbsp_pkg::result_t            res_reg;

    logic [SIZE_BITS-1:0] cap_reg, start_reg, end_reg, peak_reg, wm_reg;
    logic [SIZE_BITS-1:0] cap_next, start_next, end_next, peak_next, wm_next;
    logic                 traffic_reg, traffic_next;
    rbsp_pkg::result_t    res_next;

    logic advance;
    logic s_xfer;

    rbsp_apb_regs u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .min_capacity (min_capacity)
    );

    rbsp_step #(
        .SIZE_BITS (SIZE_BITS)
    ) u_step (
        .op           (op_reg),
        .amount       (amount_reg),
        .min_capacity (min_capacity),
        .cap_cur      (cap_reg),
        .start_cur    (start_reg),
        .end_cur      (end_reg),
        .peak_cur     (peak_reg),
        .wm_cur       (wm_reg),
        .traffic_cur  (traffic_reg),
        .cap_next     (cap_next),
        .start_next   (start_next),
        .end_next     (end_next),
        .peak_next    (peak_next),
        .wm_next      (wm_next),
        .traffic_next (traffic_next),
        .result       (res_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            op_reg     <= s_tuser;
            amount_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= '0;
            start_reg   <= '0;
            end_reg     <= '0;
            peak_reg    <= '0;
            wm_reg      <= '0;
            traffic_reg <= 1'b0;
        end else if (advance) begin
            cap_reg     <= cap_next;
            start_reg   <= start_next;
            end_reg     <= end_next;
            peak_reg    <= peak_next;
            wm_reg      <= wm_next;
            traffic_reg <= traffic_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000,
                       res_reg.status,
                       res_reg.move_bytes,
                       res_reg.move_from,
                       res_reg.relocation,
                       res_reg.free_bytes,
                       res_reg.write_offset,
                       res_reg.read_offset,
                       res_reg.capacity};

    a_cursor_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (start_reg <= end_reg) && (end_reg <= cap_reg))
        else $error("cursor order broken");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(cap_reg) && $stable(end_reg) && $stable(wm_reg))
        else $error("buffer state moved without a transfer");

    a_error_no_move: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (res_reg.status != rbsp_pkg::ST_OK) |->
        (res_reg.relocation == rbsp_pkg::RELOC_NONE) && (res_reg.move_bytes == '0))
        else $error("error result reports a move");

    a_shrink_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (res_reg.relocation == rbsp_pkg::RELOC_SHRINK) |->
        (res_reg.read_offset == '0) && (res_reg.write_offset == '0))
        else $error("shrink left live data");

endmodule
